[sv/parameter_list_key_extractor_macros.svh]
// ---------------------------------------------------------------------------
// Parameter list key extractor - assertion macros
// Clocked assertion wrappers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef PARAMETER_LIST_KEY_EXTRACTOR_MACROS_SVH
`define PARAMETER_LIST_KEY_EXTRACTOR_MACROS_SVH

// Checked only outside reset.
`define PLKE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PLKE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/plke_pkg.sv]
// ---------------------------------------------------------------------------
// Parameter list key extractor - package
// Constants, codes and helpers for the key extractor.
// ---------------------------------------------------------------------------
package plke_pkg;

    localparam int KEY_BYTES = 16;

    localparam int ID_W   = 16;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 4;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 2;
    localparam int CFG_W  = 2;

    localparam logic [IDX_W-1:0] KEY_LAST = IDX_W'(KEY_BYTES - 1);
    localparam logic [CNT_W-1:0] HDR_LAST = 2'd3;
    localparam logic [CNT_W-1:0] ID_BYTES = 2'd2;

    localparam logic [ID_W-1:0] SENTINEL_RST = 16'd1;
    localparam logic [ID_W-1:0] KEY_HASH_RST = 16'd112;
    localparam logic [ID_W-1:0] GUID_RST     = 16'd90;

    typedef enum logic [CFG_W-1:0] {
        CFG_SENTINEL = 2'd0,
        CFG_KEY_HASH = 2'd1,
        CFG_GUID     = 2'd2
    } t_cfg_idx;

    typedef enum logic [ST_W-1:0] {
        ST_BYTE     = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_KEY    = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    // Shift a byte into a 16-bit header field in payload byte order.
    function automatic logic [ID_W-1:0] take_byte(input logic [ID_W-1:0]   acc,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic              big);
        return big ? {acc[ID_W-BYTE_W-1:0], b} : {b, acc[ID_W-1:BYTE_W]};
    endfunction

endpackage

[sv/parameter_list_key_extractor.sv]
// ---------------------------------------------------------------------------
// Parameter list key extractor
// Walks the parameter list of a serialized payload and emits its key.
// ---------------------------------------------------------------------------
// One payload byte per beat enters on the slave side; tuser[0] marks the
// first byte of a payload and tuser[1] its byte order, tlast its final byte.
// The block takes a byte every cycle, sustained, and any result appears on
// the master side in the cycle after the byte that causes it, held in a single
// output register; the rate is set by the registered parser state update,
// and input backpressure follows only from a full output register that is
// not being drained. Each result is a key byte (status 0), the final key
// byte (status 1), no key found (status 2) or key truncated (status 3);
// the last result of a payload carries tlast. Configuration writes to the
// sentinel, key hash and guid ids must be made only while idle; the block itself does not enforce this.
module parameter_list_key_extractor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [plke_pkg::CFG_W-1:0]   i_cfg_idx,
    input  logic [plke_pkg::ID_W-1:0]    i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]                   s_axis_tuser,  // [0] first_byte, [1] big_endian
    input  logic                         s_axis_tlast,  // last_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,  // [7:0] key_byte, [11:8] byte_index
    output logic [1:0]                   m_axis_tuser,  // [1:0] status
    output logic                         m_axis_tlast   // last
);
    import plke_pkg::*;

    `include "parameter_list_key_extractor_macros.svh"

    logic [ID_W-1:0]   r_sentinel_id;
    logic [ID_W-1:0]   r_key_hash_id;
    logic [ID_W-1:0]   r_guid_id;

    t_phase            r_phase,        n_phase;
    logic [CNT_W-1:0]  r_hdr_cnt,      n_hdr_cnt;
    logic [ID_W-1:0]   r_entry_id,     n_entry_id;
    logic [ID_W-1:0]   r_entry_len,    n_entry_len;
    logic [ID_W-1:0]   r_skip_rem,     n_skip_rem;
    logic [IDX_W-1:0]  r_key_pos,      n_key_pos;
    logic              r_order_big,    n_order_big;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [IDX_W-1:0]  r_out_idx;
    t_status           r_out_status;
    logic              r_out_last;

    logic              accept;
    logic              push;
    logic              res_valid;
    logic [BYTE_W-1:0] res_byte;
    logic [IDX_W-1:0]  res_idx;
    t_status           res_status;
    logic              res_last;

    t_phase            ph_cur;
    logic [CNT_W-1:0]  cnt_cur;
    logic [ID_W-1:0]   id_cur;
    logic [ID_W-1:0]   len_cur;
    logic [ID_W-1:0]   len_new;
    logic [ID_W-1:0]   skip_cur;
    logic [ID_W-1:0]   skip_dec;
    logic [IDX_W-1:0]  kpos_cur;
    logic              big_cur;
    logic [BYTE_W-1:0] b;
    logic              first;
    logic              lastb;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && res_valid;

    assign b     = s_axis_tdata[BYTE_W-1:0];
    assign first = s_axis_tuser[0];
    assign lastb = s_axis_tlast;

    // A first byte restarts parsing in the same beat.
    assign ph_cur   = first ? PH_HEADER : r_phase;
    assign cnt_cur  = first ? '0 : r_hdr_cnt;
    assign id_cur   = first ? '0 : r_entry_id;
    assign len_cur  = first ? '0 : r_entry_len;
    assign skip_cur = first ? '0 : r_skip_rem;
    assign kpos_cur = first ? '0 : r_key_pos;
    assign big_cur  = first ? s_axis_tuser[1] : r_order_big;

    assign len_new  = take_byte(len_cur, b, big_cur);
    assign skip_dec = skip_cur - ID_W'(1);

    always_comb begin
        n_phase     = ph_cur;
        n_hdr_cnt   = cnt_cur;
        n_entry_id  = id_cur;
        n_entry_len = len_cur;
        n_skip_rem  = skip_cur;
        n_key_pos   = kpos_cur;
        n_order_big = big_cur;
        res_valid   = 1'b0;
        res_byte    = '0;
        res_idx     = '0;
        res_status  = ST_BYTE;
        res_last    = 1'b0;
        unique case (ph_cur)
            PH_HEADER: begin
                if (cnt_cur < ID_BYTES) begin
                    n_entry_id = take_byte(id_cur, b, big_cur);
                end else begin
                    n_entry_len = len_new;
                end
                if (cnt_cur != HDR_LAST) begin
                    n_hdr_cnt = cnt_cur + CNT_W'(1);
                    if (lastb) begin
                        n_phase    = PH_DONE;
                        res_valid  = 1'b1;
                        res_status = ST_NOTFOUND;
                        res_last   = 1'b1;
                    end
                end else begin
                    n_hdr_cnt = '0;
                    if (id_cur == r_sentinel_id) begin
                        n_phase    = PH_DONE;
                        res_valid  = 1'b1;
                        res_status = ST_NOTFOUND;
                        res_last   = 1'b1;
                    end else if (id_cur == r_key_hash_id || id_cur == r_guid_id) begin
                        n_key_pos = '0;
                        if (lastb) begin
                            n_phase    = PH_DONE;
                            res_valid  = 1'b1;
                            res_status = ST_TRUNC;
                            res_last   = 1'b1;
                        end else begin
                            n_phase = PH_KEY;
                        end
                    end else begin
                        n_skip_rem = len_new;
                        n_phase    = (len_new == '0) ? PH_HEADER : PH_SKIP;
                        if (lastb) begin
                            n_phase    = PH_DONE;
                            res_valid  = 1'b1;
                            res_status = ST_NOTFOUND;
                            res_last   = 1'b1;
                        end
                    end
                end
            end
            PH_SKIP: begin
                n_skip_rem = skip_dec;
                if (lastb) begin
                    n_phase    = PH_DONE;
                    res_valid  = 1'b1;
                    res_status = ST_NOTFOUND;
                    res_last   = 1'b1;
                end else if (skip_dec == '0) begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = '0;
                end
            end
            PH_KEY: begin
                if (kpos_cur >= KEY_LAST) begin
                    n_phase    = PH_DONE;
                    n_key_pos  = '0;
                    res_valid  = 1'b1;
                    res_byte   = b;
                    res_idx    = kpos_cur;
                    res_status = ST_COMPLETE;
                    res_last   = 1'b1;
                end else if (lastb) begin
                    n_phase    = PH_DONE;
                    res_valid  = 1'b1;
                    res_status = ST_TRUNC;
                    res_last   = 1'b1;
                end else begin
                    n_key_pos  = kpos_cur + IDX_W'(1);
                    res_valid  = 1'b1;
                    res_byte   = b;
                    res_idx    = kpos_cur;
                    res_status = ST_BYTE;
                end
            end
            PH_IDLE, PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sentinel_id <= SENTINEL_RST;
            r_key_hash_id <= KEY_HASH_RST;
            r_guid_id     <= GUID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENTINEL: r_sentinel_id <= i_cfg_data;
                CFG_KEY_HASH: r_key_hash_id <= i_cfg_data;
                CFG_GUID:     r_guid_id     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hdr_cnt   <= '0;
            r_entry_id  <= '0;
            r_entry_len <= '0;
            r_skip_rem  <= '0;
            r_key_pos   <= '0;
            r_order_big <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_entry_id  <= n_entry_id;
            r_entry_len <= n_entry_len;
            r_skip_rem  <= n_skip_rem;
            r_key_pos   <= n_key_pos;
            r_order_big <= n_order_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_byte   <= res_byte;
            r_out_idx    <= res_idx;
            r_out_status <= res_status;
            r_out_last   <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - BYTE_W - IDX_W){1'b0}}, r_out_idx, r_out_byte};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    `PLKE_ASSERT(a_status_last, r_out_valid && r_out_status != ST_BYTE |-> r_out_last, "non-byte status without last")
    `PLKE_ASSERT(a_complete_idx, r_out_valid && r_out_status == ST_COMPLETE |-> r_out_idx == KEY_LAST, "key complete on wrong index")
    `PLKE_ASSERT(a_last_done, push && res_last |=> r_phase == PH_DONE, "final result without decision")
    `PLKE_ASSERT(a_no_overrun, push && r_out_valid |-> m_axis_tready, "result register overwritten")

endmodule
